>>> design/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, side-band structs and the output saturation function of the
// quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_W    = 16;  // Q8.8 coefficients
  localparam int ROOT_W    = 32;  // Q16.16 roots
  localparam int SQ_X_W    = 64;  // radicand |D| << 30, left aligned
  localparam int SQ_STEPS  = 32;  // one root bit per cell
  localparam int SQ_REM_W  = 34;  // partial remainder, at most 2*root
  localparam int NUM_W     = 33;  // rounded numerator magnitude, one quotient bit per cell
  localparam int DIV_REM_W = 16;  // remainder stays below |a| <= 2^15
  localparam int DISC_W    = 35;  // b*b - 4ac, signed
  localparam int MAG_W     = 33;  // |D|
  localparam int NUMS_W    = 34;  // signed numerator at scale 2^15

  // travels with a word through the square root cells
  typedef struct packed {
    logic [COEF_W-1:0] a;
    logic [COEF_W-1:0] b;
    logic              cplx;
    logic              lze;
  } sq_side_t;

  // travels with a word through the divider cells
  typedef struct packed {
    logic neg1;
    logic neg2;
    logic cplx;
    logic lze;
  } div_side_t;

  // magnitude plus sign to saturated two's complement
  function automatic logic [ROOT_W-1:0] sat_root(input logic [NUM_W-1:0] q,
                                                 input logic neg);
    logic [ROOT_W-1:0] res;
    if (neg) begin
      if (q[NUM_W-1] || (q[ROOT_W-1] && (|q[ROOT_W-2:0]))) begin
        res = {1'b1, {(ROOT_W-1){1'b0}}};
      end else begin
        res = -q[ROOT_W-1:0];
      end
    end else begin
      if (q[NUM_W-1] || q[ROOT_W-1]) begin
        res = {1'b0, {(ROOT_W-1){1'b1}}};
      end else begin
        res = q[ROOT_W-1:0];
      end
    end
    return res;
  endfunction

endpackage

>>> design/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One digit-pair step of the integer square root; resolves one root bit.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell
  import qrs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_i,
  input  logic [SQ_X_W-1:0]   x_i,
  input  logic [ROOT_W-1:0]   root_i,
  input  logic [SQ_REM_W-1:0] rem_i,
  input  sq_side_t            side_i,
  output logic                vld_o,
  output logic [SQ_X_W-1:0]   x_o,
  output logic [ROOT_W-1:0]   root_o,
  output logic [SQ_REM_W-1:0] rem_o,
  output sq_side_t            side_o
);

  logic                vld_r;
  logic [SQ_X_W-1:0]   x_r, x_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [SQ_REM_W-1:0] rem_r, rem_nxt;
  sq_side_t            side_r;
  logic [SQ_REM_W+1:0] t, trial, diff;
  logic                ge;

  always_comb begin
    t        = {rem_i, x_i[SQ_X_W-1 -: 2]};
    trial    = {{(SQ_REM_W-ROOT_W){1'b0}}, root_i, 2'b01};
    diff     = t - trial;
    ge       = (t >= trial);
    rem_nxt  = ge ? diff[SQ_REM_W-1:0] : t[SQ_REM_W-1:0];
    root_nxt = {root_i[ROOT_W-2:0], ge};
    x_nxt    = {x_i[SQ_X_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      root_r <= root_nxt;
      rem_r  <= rem_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign x_o    = x_r;
  assign root_o = root_r;
  assign rem_o  = rem_r;
  assign side_o = side_r;

endmodule

>>> design/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// qrs_div_cell
// One restoring-division step on two lanes sharing a divisor.
// ----------------------------------------------------------------------------
module qrs_div_cell
  import qrs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic [COEF_W-1:0]    d_i,
  input  logic [NUM_W-1:0]     nq1_i,
  input  logic [NUM_W-1:0]     nq2_i,
  input  logic [DIV_REM_W-1:0] rem1_i,
  input  logic [DIV_REM_W-1:0] rem2_i,
  input  div_side_t            side_i,
  output logic                 vld_o,
  output logic [COEF_W-1:0]    d_o,
  output logic [NUM_W-1:0]     nq1_o,
  output logic [NUM_W-1:0]     nq2_o,
  output logic [DIV_REM_W-1:0] rem1_o,
  output logic [DIV_REM_W-1:0] rem2_o,
  output div_side_t            side_o
);

  logic                 vld_r;
  logic [COEF_W-1:0]    d_r;
  logic [NUM_W-1:0]     nq1_r, nq1_nxt, nq2_r, nq2_nxt;
  logic [DIV_REM_W-1:0] rem1_r, rem1_nxt, rem2_r, rem2_nxt;
  div_side_t            side_r;
  logic [DIV_REM_W:0]   t1, t2, dd, s1, s2;
  logic                 ge1, ge2;

  always_comb begin
    dd       = {1'b0, d_i};
    t1       = {rem1_i, nq1_i[NUM_W-1]};
    t2       = {rem2_i, nq2_i[NUM_W-1]};
    s1       = t1 - dd;
    s2       = t2 - dd;
    ge1      = (t1 >= dd);
    ge2      = (t2 >= dd);
    rem1_nxt = ge1 ? s1[DIV_REM_W-1:0] : t1[DIV_REM_W-1:0];
    rem2_nxt = ge2 ? s2[DIV_REM_W-1:0] : t2[DIV_REM_W-1:0];
    nq1_nxt  = {nq1_i[NUM_W-2:0], ge1};
    nq2_nxt  = {nq2_i[NUM_W-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_i;
      nq1_r  <= nq1_nxt;
      nq2_r  <= nq2_nxt;
      rem1_r <= rem1_nxt;
      rem2_r <= rem2_nxt;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign d_o    = d_r;
  assign nq1_o  = nq1_r;
  assign nq2_o  = nq2_r;
  assign rem1_o = rem1_r;
  assign rem2_o = rem2_r;
  assign side_o = side_r;

endmodule

>>> design/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Roots of a*x^2 + b*x + c from Q8.8 coefficients, Q16.16 saturated results.
// ----------------------------------------------------------------------------
//  channel | ports                                        | dir
//  --------+----------------------------------------------+-----
//  input   | in_valid, in_ready, in_coef_a/b/c            | in
//  result  | out_valid, out_ready, out_root1/2_real/imag, | out
//          | out_is_complex, out_leading_zero_error       |
//
// One word accepted per cycle unless the output stalls; the stages in order are:
// product stage, discriminant stage, 32 square root cells, numerator stage,
// 33 divider cells and the output register. The cell rows set the latency.
// The whole pipe advances together whenever the output register is empty or
// being taken, so a stalled result holds every stage in place.
// Reset clears valid bits only; no clearing pass is needed.
// ----------------------------------------------------------------------------
module quadratic_root_solver
  import qrs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [COEF_W-1:0] in_coef_a,
  input  logic signed [COEF_W-1:0] in_coef_b,
  input  logic signed [COEF_W-1:0] in_coef_c,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [ROOT_W-1:0] out_root1_real,
  output logic signed [ROOT_W-1:0] out_root1_imag,
  output logic signed [ROOT_W-1:0] out_root2_real,
  output logic signed [ROOT_W-1:0] out_root2_imag,
  output logic                     out_is_complex,
  output logic                     out_leading_zero_error
);

  logic en;

  // ---- stage P: products b*b and a*c --------------------------------------
  logic                         p_vld_r;
  logic signed [COEF_W-1:0]     p_a_r, p_b_r;
  logic signed [2*COEF_W-1:0]   p_bb_r, p_ac_r;

  // ---- stage D: discriminant, feeds square root row -----------------------
  logic signed [DISC_W-1:0]     disc;
  logic [MAG_W-1:0]             mag;
  sq_side_t                     d_side;

  // square root row
  logic                sq_vld  [0:SQ_STEPS];
  logic [SQ_X_W-1:0]   sq_x    [0:SQ_STEPS];
  logic [ROOT_W-1:0]   sq_root [0:SQ_STEPS];
  logic [SQ_REM_W-1:0] sq_rem  [0:SQ_STEPS];
  sq_side_t            sq_side [0:SQ_STEPS];

  // ---- stage N: numerators ------------------------------------------------
  logic signed [NUMS_W-1:0] nb, sv, n1, n2;
  logic [NUM_W-1:0]         m1, m2;
  logic [COEF_W-1:0]        ud;
  sq_side_t                 ns;
  div_side_t                n_side;

  // divider row
  logic                 dv_vld  [0:NUM_W];
  logic [COEF_W-1:0]    dv_d    [0:NUM_W];
  logic [NUM_W-1:0]     dv_nq1  [0:NUM_W];
  logic [NUM_W-1:0]     dv_nq2  [0:NUM_W];
  logic [DIV_REM_W-1:0] dv_rem1 [0:NUM_W];
  logic [DIV_REM_W-1:0] dv_rem2 [0:NUM_W];
  div_side_t            dv_side [0:NUM_W];

  // ---- output register ----------------------------------------------------
  logic              out_valid_r;
  logic [ROOT_W-1:0] r1r_r, r1i_r, r2r_r, r2i_r;
  logic              cplx_r, lze_r;
  logic [ROOT_W-1:0] r1r_nxt, r1i_nxt, r2r_nxt, r2i_nxt;
  logic [ROOT_W-1:0] q1v, q2v, q2n;
  div_side_t         fs;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // stage P
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_a_r  <= in_coef_a;
      p_b_r  <= in_coef_b;
      p_bb_r <= in_coef_b * in_coef_b;
      p_ac_r <= in_coef_a * in_coef_c;
    end
  end

  // stage D: D = b*b - 4ac, radicand |D| << 30
  always_comb begin
    disc = DISC_W'(p_bb_r) - (DISC_W'(p_ac_r) <<< 2);
    mag  = disc[DISC_W-1] ? MAG_W'(-disc) : MAG_W'(disc);
    d_side.a    = p_a_r;
    d_side.b    = p_b_r;
    d_side.cplx = disc[DISC_W-1];
    d_side.lze  = (p_a_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld[0] <= 1'b0;
    end else if (en) begin
      sq_vld[0] <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x[0]    <= {1'b0, mag, 30'b0};
      sq_root[0] <= '0;
      sq_rem[0]  <= '0;
      sq_side[0] <= d_side;
    end
  end

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
    qrs_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (sq_vld[i]),
      .x_i    (sq_x[i]),
      .root_i (sq_root[i]),
      .rem_i  (sq_rem[i]),
      .side_i (sq_side[i]),
      .vld_o  (sq_vld[i+1]),
      .x_o    (sq_x[i+1]),
      .root_o (sq_root[i+1]),
      .rem_o  (sq_rem[i+1]),
      .side_o (sq_side[i+1])
    );
  end

  // stage N: real pair -> (nb+s, nb-s); complex -> (nb, s).
  // Lanes carry rounded magnitudes; sign is numerator sign xor sign of a.
  always_comb begin
    ns  = sq_side[SQ_STEPS];
    nb  = -(NUMS_W'(signed'(ns.b)) <<< 15);
    sv  = signed'({{(NUMS_W-ROOT_W){1'b0}}, sq_root[SQ_STEPS]});
    n1  = ns.cplx ? nb : nb + sv;
    n2  = ns.cplx ? sv : nb - sv;
    ud  = ns.a[COEF_W-1] ? -ns.a : ns.a;
    m1  = n1[NUMS_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
    m2  = n2[NUMS_W-1] ? NUM_W'(-n2) : NUM_W'(n2);
    n_side.neg1 = n1[NUMS_W-1] ^ ns.a[COEF_W-1];
    n_side.neg2 = n2[NUMS_W-1] ^ ns.a[COEF_W-1];
    n_side.cplx = ns.cplx;
    n_side.lze  = ns.lze;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= sq_vld[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_d[0]    <= ud;
      dv_nq1[0]  <= m1 + NUM_W'(ud >> 1);
      dv_nq2[0]  <= m2 + NUM_W'(ud >> 1);
      dv_rem1[0] <= '0;
      dv_rem2[0] <= '0;
      dv_side[0] <= n_side;
    end
  end

  for (genvar j = 0; j < NUM_W; j++) begin : g_dv
    qrs_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (dv_vld[j]),
      .d_i    (dv_d[j]),
      .nq1_i  (dv_nq1[j]),
      .nq2_i  (dv_nq2[j]),
      .rem1_i (dv_rem1[j]),
      .rem2_i (dv_rem2[j]),
      .side_i (dv_side[j]),
      .vld_o  (dv_vld[j+1]),
      .d_o    (dv_d[j+1]),
      .nq1_o  (dv_nq1[j+1]),
      .nq2_o  (dv_nq2[j+1]),
      .rem1_o (dv_rem1[j+1]),
      .rem2_o (dv_rem2[j+1]),
      .side_o (dv_side[j+1])
    );
  end

  // final assembly: saturate, mirror imaginary part, zero on error
  always_comb begin
    fs  = dv_side[NUM_W];
    q1v = sat_root(dv_nq1[NUM_W], fs.neg1);
    q2v = sat_root(dv_nq2[NUM_W], fs.neg2);
    q2n = sat_root(dv_nq2[NUM_W], !fs.neg2);
    if (fs.lze) begin
      r1r_nxt = '0;
      r1i_nxt = '0;
      r2r_nxt = '0;
      r2i_nxt = '0;
    end else if (fs.cplx) begin
      r1r_nxt = q1v;
      r2r_nxt = q1v;
      r1i_nxt = q2v;
      r2i_nxt = q2n;
    end else begin
      r1r_nxt = q1v;
      r2r_nxt = q2v;
      r1i_nxt = '0;
      r2i_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld[NUM_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1r_r  <= r1r_nxt;
      r1i_r  <= r1i_nxt;
      r2r_r  <= r2r_nxt;
      r2i_r  <= r2i_nxt;
      cplx_r <= fs.cplx && !fs.lze;
      lze_r  <= fs.lze;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_root1_real         = r1r_r;
  assign out_root1_imag         = r1i_r;
  assign out_root2_real         = r2r_r;
  assign out_root2_imag         = r2i_r;
  assign out_is_complex         = cplx_r;
  assign out_leading_zero_error = lze_r;

endmodule

>>> dv/quadratic_root_solver_tb.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_tb
// Drives coefficient words through the root solver under random idling on
// both channels and compares every result word against an in-bench predictor.
// ----------------------------------------------------------------------------
module quadratic_root_solver_tb;
  import qrs_pkg::*;

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
  } coef_t;

  typedef struct packed {
    logic signed [ROOT_W-1:0] r1re;
    logic signed [ROOT_W-1:0] r1im;
    logic signed [ROOT_W-1:0] r2re;
    logic signed [ROOT_W-1:0] r2im;
    logic                     cplx;
    logic                     lze;
  } roots_t;

  localparam int LIMIT = 200000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [COEF_W-1:0] in_coef_a, in_coef_b, in_coef_c;
  logic signed [ROOT_W-1:0] out_root1_real, out_root1_imag;
  logic signed [ROOT_W-1:0] out_root2_real, out_root2_imag;
  logic out_is_complex, out_leading_zero_error;

  coef_t  coef_q[$];      // words waiting to be driven
  roots_t roots_q[$];     // expected roots, oldest first
  int     send_idle = 0;  // idle percentages, changed per phase
  int     recv_idle = 0;
  bit     hold = 0;       // sender pause until the pipe drains
  int     errors = 0;
  int     cycles = 0;

  quadratic_root_solver DUT (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // bitwise integer square root, truncated
  function automatic longint unsigned isqrt(input longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // n/d rounded half away from zero, saturated to 32 bits
  function automatic logic [ROOT_W-1:0] quot_sat(input longint n, input longint d);
    bit neg;
    longint unsigned un, ud, q;
    neg = (n < 0) != (d < 0);
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = (un + (ud >> 1)) / ud;
    if (neg) return (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-longint'(q));
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(q);
  endfunction

  function automatic roots_t solve_roots(input coef_t w);
    roots_t r;
    longint a, b, c, disc, nb;
    longint unsigned mag, s;
    r = '0;
    a = w.a; b = w.b; c = w.c;
    if (a == 0) begin
      r.lze = 1'b1;
      return r;
    end
    disc = b * b - 4 * a * c;
    mag = (disc < 0) ? -disc : disc;
    s = isqrt(mag << 30);
    nb = -b * 32768;
    if (disc >= 0) begin
      r.r1re = quot_sat(nb + longint'(s), a);
      r.r2re = quot_sat(nb - longint'(s), a);
    end else begin
      r.r1re = quot_sat(nb, a);
      r.r2re = r.r1re;
      r.r1im = quot_sat(longint'(s), a);
      r.r2im = quot_sat(-longint'(s), a);
      r.cplx = 1'b1;
    end
    return r;
  endfunction

  function automatic coef_t mk(input int a, input int b, input int c);
    coef_t w;
    w.a = a[15:0]; w.b = b[15:0]; w.c = c[15:0];
    return w;
  endfunction

  // random coefficient: full range half the time, otherwise small or extreme
  function automatic logic [15:0] rnd_coef();
    case ($urandom_range(0, 5))
      0: return 16'($signed($urandom_range(0, 1024)) - 512);
      1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      2: return 16'($signed($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // driver: pops pending words, holds valid until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (coef_q.size() > 0 && !hold && $urandom_range(0, 99) >= send_idle) begin
        in_valid  <= 1'b1;
        in_coef_a <= coef_q[0].a;
        in_coef_b <= coef_q[0].b;
        in_coef_c <= coef_q[0].c;
        roots_q.push_back(solve_roots(coef_q[0]));
        void'(coef_q.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: takes result words, compares against the oldest expectation
  always @(posedge clk) begin
    roots_t e;
    cycles <= cycles + 1;
    if (rst_n) out_ready <= ($urandom_range(0, 99) >= recv_idle);
    else out_ready <= 1'b0;
    if (rst_n && out_valid && out_ready) begin
      if (roots_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = roots_q.pop_front();
        if (out_root1_real !== e.r1re) begin
          $error("root1_real exp %0d got %0d", e.r1re, out_root1_real); errors++;
        end
        if (out_root1_imag !== e.r1im) begin
          $error("root1_imag exp %0d got %0d", e.r1im, out_root1_imag); errors++;
        end
        if (out_root2_real !== e.r2re) begin
          $error("root2_real exp %0d got %0d", e.r2re, out_root2_real); errors++;
        end
        if (out_root2_imag !== e.r2im) begin
          $error("root2_imag exp %0d got %0d", e.r2im, out_root2_imag); errors++;
        end
        if (out_is_complex !== e.cplx) begin
          $error("is_complex exp %0d got %0d", e.cplx, out_is_complex); errors++;
        end
        if (out_leading_zero_error !== e.lze) begin
          $error("leading_zero_error exp %0d got %0d", e.lze, out_leading_zero_error);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int n;
    rst_n = 0; in_valid = 0; out_ready = 0;
    in_coef_a = '0; in_coef_b = '0; in_coef_c = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1;

    // directed: zero lead, real, double, complex, extremes, saturation
    coef_q.push_back(mk(0, 256, 256));
    coef_q.push_back(mk(0, -32768, 32767));
    coef_q.push_back(mk(256, -768, 512));      // roots 1 and 2
    coef_q.push_back(mk(256, 512, 256));       // double root -1
    coef_q.push_back(mk(256, 0, 256));         // +/- i
    coef_q.push_back(mk(-256, 0, 256));        // negative lead
    coef_q.push_back(mk(-256, 0, -256));       // complex, negative lead
    coef_q.push_back(mk(1, 32767, 0));         // roots 0 and -32767, just inside range
    coef_q.push_back(mk(1, -32768, 0));
    coef_q.push_back(mk(-1, 32767, 0));
    coef_q.push_back(mk(1, 0, 32767));
    coef_q.push_back(mk(-32768, -32768, -32768));
    coef_q.push_back(mk(32767, 32767, 32767));
    coef_q.push_back(mk(-32768, 32767, 32767));
    coef_q.push_back(mk(32767, -32768, -32768));
    coef_q.push_back(mk(-1, -1, -1));
    coef_q.push_back(mk(1, 1, 1));
    coef_q.push_back(mk(1, 2, 1));
    coef_q.push_back(mk(2, 1, 0));             // roots 0 and -0.5
    coef_q.push_back(mk(-32768, 0, 0));

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 36 : (ph == 1) ? 45 : 0;
      recv_idle = (ph == 0) ? 45 : (ph == 1) ? 36 : 0;
      n = (ph == 2) ? 310 : 320;
      for (int i = 0; i < n; i++) coef_q.push_back({rnd_coef(), rnd_coef(), rnd_coef()});
      wait (coef_q.size() == 0);
      if (ph == 0) begin
        // sender holds off until the pipe has emptied
        hold = 1;
        wait (roots_q.size() == 0);
        hold = 0;
      end
    end
    @(posedge clk);
    // nothing pending, nothing on the input, every expectation consumed
    wait (coef_q.size() == 0 && !in_valid && roots_q.size() == 0);
    repeat (80) @(posedge clk);
    if (errors == 0 && roots_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
